### sv/matrix_keypad_debounce_scanner_top_defines.svh
// Assertion macros shared by the checker files of the keypad scanner.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside of reset.
`define MKDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define MKDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mkds_pkg.sv
package mkds_pkg;

   // Matrix geometry.
   localparam int ROWS      = 8;
   localparam int COLUMNS   = 8;
   localparam int CROSSINGS = ROWS * COLUMNS;

   // Fixed field widths.
   localparam int LEVELS_W = 64;
   localparam int SEL_W    = 6;
   localparam int KEY_W    = 3;
   localparam int COUNT_W  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_ACTIVE_LOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_LIMIT  = 1'd1;

   // Register reset values.
   localparam logic               ROWS_ACTIVE_LOW_RESET = 1'b1;
   localparam logic [COUNT_W-1:0] DEBOUNCE_LIMIT_RESET  = 8'd5;

endpackage

### sv/matrix_keypad_debounce_scanner_top.sv
// Matrix keypad scanner with debounce. One matrix snapshot is taken per cycle on the
// req_ channel while the input side does not stall; each snapshot passes an input register
// and one pass of pick and counter logic, and a confirmed result is then held in the output
// register and offered on the rsp_ channel until it transfers out. A result (column and row) is
// produced only when a key press is confirmed. The input side stalls only while a result
// sits in the output register and the rsp_ side stalls.
// Configuration writes take effect at the next edge and should be made while idle.
module matrix_keypad_debounce_scanner_top
   import mkds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [LEVELS_W-1:0]   req_crossing_levels,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KEY_W-1:0]      rsp_key_column,
   output logic [KEY_W-1:0]      rsp_key_row,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_DEBOUNCE = 2'd1,
      PHASE_PRESSED  = 2'd2
   } phase_type;

   logic                 rows_active_low_ff, rows_active_low_in;
   logic [COUNT_W-1:0]   debounce_limit_ff, debounce_limit_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [LEVELS_W-1:0]  s1_levels_ff, s1_levels_in;
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [KEY_W-1:0]     held_col_ff, held_col_in;
   logic [KEY_W-1:0]     held_row_ff, held_row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [KEY_W-1:0]     rsp_row_ff, rsp_row_in;

   logic                 req_accept;
   logic                 advance;
   logic [CROSSINGS-1:0] pressed;
   logic                 pick_found;
   logic [KEY_W-1:0]     pick_col;
   logic [KEY_W-1:0]     pick_row;
   logic [SEL_W-1:0]     held_sel;
   logic                 held_down;
   logic [COUNT_W-1:0]   limit_eff;
   logic [COUNT_W-1:0]   count_up;

   // The staged snapshot moves on when the output register is free or being emptied.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_column = rsp_col_ff;
   assign rsp_key_row    = rsp_row_ff;

   // Per-crossing pressed flags after polarity.
   assign pressed = s1_levels_ff[CROSSINGS-1:0] ^ {CROSSINGS{rows_active_low_ff}};

   // Priority pick: lowest column first, then lowest row.
   always_comb begin
      pick_found = 1'b0;
      pick_col   = '0;
      pick_row   = '0;
      for (int c = COLUMNS - 1; c >= 0; c--) begin
         for (int r = ROWS - 1; r >= 0; r--) begin
            if (pressed[c * ROWS + r]) begin
               pick_found = 1'b1;
               pick_col   = KEY_W'(c);
               pick_row   = KEY_W'(r);
            end
         end
      end
   end

   // Level of the latched key.
   assign held_sel  = SEL_W'(int'(held_col_ff) * ROWS + int'(held_row_ff));
   assign held_down = s1_levels_ff[held_sel] ^ rows_active_low_ff;

   assign limit_eff = (debounce_limit_ff == '0) ? COUNT_W'(1) : debounce_limit_ff;
   assign count_up  = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);

   // Next state of the scanner and the output register.
   always_comb begin
      rows_active_low_in = rows_active_low_ff;
      debounce_limit_in  = debounce_limit_ff;
      s1_valid_in        = s1_valid_ff;
      s1_levels_in       = s1_levels_ff;
      phase_in           = phase_ff;
      count_in           = count_ff;
      held_col_in        = held_col_ff;
      held_row_in        = held_row_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_col_in         = rsp_col_ff;
      rsp_row_in         = rsp_row_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS_ACTIVE_LOW: rows_active_low_in = csr_write_data[0];
            CSR_DEBOUNCE_LIMIT:  debounce_limit_in  = csr_write_data;
            default: ;
         endcase
      end

      // A result leaves on its transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         s1_valid_in  = 1'b1;
         s1_levels_in = req_crossing_levels;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      if (advance) begin
         case (phase_ff)
            PHASE_DEBOUNCE, PHASE_PRESSED: begin
               if (!held_down) begin
                  // Release decays the count; at one or below the scanner goes idle.
                  if (count_ff <= COUNT_W'(1)) begin
                     count_in = '0;
                     phase_in = PHASE_IDLE;
                  end else begin
                     count_in = count_ff - COUNT_W'(1);
                  end
               end else if (phase_ff == PHASE_DEBOUNCE) begin
                  count_in = count_up;
                  if (count_up >= limit_eff) begin
                     phase_in     = PHASE_PRESSED;
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = held_col_ff;
                     rsp_row_in   = held_row_ff;
                  end
               end else begin
                  // Held key: count saturates at the limit.
                  count_in = (count_ff < limit_eff) ? count_ff + COUNT_W'(1) : limit_eff;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
               if (pick_found) begin
                  held_col_in = pick_col;
                  held_row_in = pick_row;
                  count_in    = COUNT_W'(1);
                  phase_in    = PHASE_DEBOUNCE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_active_low_ff <= ROWS_ACTIVE_LOW_RESET;
         debounce_limit_ff  <= DEBOUNCE_LIMIT_RESET;
         s1_valid_ff        <= 1'b0;
         phase_ff           <= PHASE_IDLE;
         count_ff           <= '0;
         held_col_ff        <= '0;
         held_row_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rows_active_low_ff <= rows_active_low_in;
         debounce_limit_ff  <= debounce_limit_in;
         s1_valid_ff        <= s1_valid_in;
         phase_ff           <= phase_in;
         count_ff           <= count_in;
         held_col_ff        <= held_col_in;
         held_row_ff        <= held_row_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      s1_levels_ff <= s1_levels_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

endmodule

### sv/mkds_checker.sv
`include "matrix_keypad_debounce_scanner_top_defines.svh"

// Port-level checks of the keypad scanner.
module mkds_checker
   import mkds_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [KEY_W-1:0] rsp_key_column,
   input logic [KEY_W-1:0] rsp_key_row
);

   // No result is pending right after reset.
   `MKDS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // The input side stalls only behind a stalled result.
   `MKDS_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a stalled result")

   // A transferred result is never directly followed by another valid result.
   `MKDS_ASSERT(a_no_repeat, clock, reset, (rsp_valid && !rsp_stall) |=> !rsp_valid, "result directly after a result transfer")

   // A stalled result holds its payload.
   `MKDS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_key_column) && $stable(rsp_key_row)), "stalled result changed")

endmodule

bind matrix_keypad_debounce_scanner_top mkds_checker u_mkds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_key_column (rsp_key_column),
   .rsp_key_row    (rsp_key_row)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import mkds_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   // A snapshot's result passes the input and output registers before it can transfer out;
   // allow some margin.
   localparam int SETTLE_CYCLES  = 4;

   typedef enum logic [1:0] {
      SCAN_IDLE     = 2'd0,
      SCAN_DEBOUNCE = 2'd1,
      SCAN_PRESSED  = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic [KEY_W-1:0] column;
      logic [KEY_W-1:0] row;
   } key_position_type;

   // Tracks the scanner state, predicts confirmed presses and checks them in order.
   class keypress_tracker;
      logic                 active_low;
      logic [COUNT_W-1:0]   limit;
      scan_phase_type       phase;
      logic [COUNT_W-1:0]   count;
      logic [KEY_W-1:0]     held_column;
      logic [KEY_W-1:0]     held_row;
      key_position_type     expected_presses[$];
      int                   failures;
      int                   presses_checked;

      function new();
         active_low      = ROWS_ACTIVE_LOW_RESET;
         limit           = DEBOUNCE_LIMIT_RESET;
         phase           = SCAN_IDLE;
         count           = '0;
         held_column     = '0;
         held_row        = '0;
         failures        = 0;
         presses_checked = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ROWS_ACTIVE_LOW: active_low = data[0];
            CSR_DEBOUNCE_LIMIT:  limit = data;
            default: ;
         endcase
      endfunction

      function bit crossing_down(logic [LEVELS_W-1:0] levels, int column, int row);
         return levels[column * ROWS + row] != active_low;
      endfunction

      function int pending();
         return expected_presses.size();
      endfunction

      // Advances the predicted state by one accepted snapshot.
      function void note_snapshot(logic [LEVELS_W-1:0] levels);
         int               eff_limit;
         bit               down;
         key_position_type press;
         eff_limit = (limit < 1) ? 1 : int'(limit);

         // Idle: latch the first pressed crossing, columns first, then rows.
         if (phase != SCAN_DEBOUNCE && phase != SCAN_PRESSED) begin
            phase = SCAN_IDLE;
            for (int c = 0; c < COLUMNS; c++) begin
               for (int r = 0; r < ROWS; r++) begin
                  if (crossing_down(levels, c, r)) begin
                     held_column = c[KEY_W-1:0];
                     held_row    = r[KEY_W-1:0];
                     count       = 8'd1;
                     phase       = SCAN_DEBOUNCE;
                     return;
                  end
               end
            end
            return;
         end

         down = crossing_down(levels, held_column, held_row);

         // A release counts down and drops to idle at the bottom.
         if (!down) begin
            if (count <= 1) begin
               count = '0;
               phase = SCAN_IDLE;
            end else begin
               count = count - 8'd1;
            end
            return;
         end

         if (phase == SCAN_DEBOUNCE) begin
            if (count < 8'd255)
               count = count + 8'd1;
            if (int'(count) >= eff_limit) begin
               phase        = SCAN_PRESSED;
               press.column = held_column;
               press.row    = held_row;
               expected_presses.push_back(press);
            end
            return;
         end

         // Held while pressed: saturate at the limit, clamping down if it was lowered.
         if (int'(count) < eff_limit)
            count = count + 8'd1;
         else
            count = eff_limit[COUNT_W-1:0];
      endfunction

      task report_mismatch(string what);
         failures++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_press(logic [KEY_W-1:0] column, logic [KEY_W-1:0] row);
         key_position_type want;
         if (expected_presses.size() == 0) begin
            report_mismatch($sformatf("unexpected press column %0d row %0d", column, row));
            return;
         end
         want = expected_presses.pop_front();
         presses_checked++;
         if (column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d", column, want.column));
         if (row !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", row, want.row));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LEVELS_W-1:0]   req_crossing_levels = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KEY_W-1:0]      rsp_key_column;
   logic [KEY_W-1:0]      rsp_key_row;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   keypress_tracker tracker = new();

   bit calm = 1'b0;
   bit cur_active_low = ROWS_ACTIVE_LOW_RESET;
   int cur_limit = DEBOUNCE_LIMIT_RESET;
   int snapshots_sent = 0;
   int settings_applied = 0;
   int quiet_cycles = 0;

   matrix_keypad_debounce_scanner_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_crossing_levels (req_crossing_levels),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_key_column      (rsp_key_column),
      .rsp_key_row         (rsp_key_row),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: check each transfer out and stall now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_press(rsp_key_column, rsp_key_row);
         rsp_stall <= !calm && ($urandom_range(99) < 6);
      end
   end

   // Count cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Watchdog expired with %0d presses outstanding.", tracker.pending());
      $display("Test completed with failures");
      $finish;
   end

   // Converts a set of pressed crossings into raw pin levels for the current polarity.
   function automatic logic [LEVELS_W-1:0] levels_of(logic [LEVELS_W-1:0] pressed);
      return cur_active_low ? ~pressed : pressed;
   endfunction

   function automatic logic [LEVELS_W-1:0] random_levels();
      return {$urandom, $urandom};
   endfunction

   task automatic send_snapshot(logic [LEVELS_W-1:0] levels);
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_crossing_levels <= levels;
      do
         @(posedge clock);
      while (req_stall);
      tracker.note_snapshot(levels);
      snapshots_sent++;
   endtask

   // Hold off the sender until every predicted press has come out, then let the pipe settle.
   task automatic drain_presses();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_scanner(bit active_low, int limit);
      logic [CSR_DATA_W-1:0] polarity_word;
      polarity_word    = $urandom;
      polarity_word[0] = active_low;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ROWS_ACTIVE_LOW;
      csr_write_data   <= polarity_word;
      @(posedge clock);
      tracker.set_register(CSR_ROWS_ACTIVE_LOW, polarity_word);
      csr_index        <= CSR_DEBOUNCE_LIMIT;
      csr_write_data   <= limit[CSR_DATA_W-1:0];
      @(posedge clock);
      tracker.set_register(CSR_DEBOUNCE_LIMIT, limit[CSR_DATA_W-1:0]);
      csr_write_enable <= 1'b0;
      cur_active_low = active_low;
      cur_limit      = limit;
      settings_applied++;
   endtask

   // One key press with bounce: the pick, a hold around the limit, then a release.
   task automatic run_keystroke();
      int unsigned         column, row, key, hold_len, release_len, hold_min;
      logic [LEVELS_W-1:0] key_bit, higher, pressed;
      column  = $urandom_range(COLUMNS - 1);
      row     = $urandom_range(ROWS - 1);
      key     = column * ROWS + row;
      key_bit = 64'd1 << key;
      higher  = ~((64'd1 << (key + 1)) - 64'd1);

      // Other keys may be down at the pick, but only ones scanned later.
      pressed = key_bit;
      if ($urandom_range(1))
         pressed |= higher & random_levels();
      send_snapshot(levels_of(pressed));

      hold_min = (cur_limit > 1) ? cur_limit - 1 : 1;
      hold_len = $urandom_range(hold_min, cur_limit + 6);
      for (int i = 0; i < hold_len; i++) begin
         pressed = key_bit;
         if ($urandom_range(99) < 30)
            pressed |= random_levels();
         if ($urandom_range(99) < 10)
            pressed &= ~key_bit;
         send_snapshot(levels_of(pressed));
      end

      release_len = (cur_limit <= 16) ? $urandom_range(1, cur_limit + 3) : $urandom_range(1, 24);
      for (int i = 0; i < release_len; i++) begin
         pressed = '0;
         if ($urandom_range(99) < 15)
            pressed = random_levels() & ~key_bit;
         if ($urandom_range(99) < 10)
            pressed |= key_bit;
         send_snapshot(levels_of(pressed));
      end
   endtask

   task automatic run_phase(bit active_low, int limit, int budget, bit no_idling);
      int start;
      drain_presses();
      program_scanner(active_low, limit);
      calm  = no_idling;
      start = snapshots_sent;
      while (snapshots_sent - start < budget) begin
         if ($urandom_range(99) < 10)
            send_snapshot(random_levels());
         else
            run_keystroke();
      end
      calm = 1'b0;
   endtask

   // Reset settings: nothing pressed, the first and the last crossing, a bounce.
   task automatic run_directed();
      send_snapshot({LEVELS_W{1'b1}});
      repeat (5) send_snapshot('0);
      repeat (5) send_snapshot({LEVELS_W{1'b1}});
      send_snapshot(~(64'd1 << 63));
      send_snapshot(~(64'd1 << 63));
      send_snapshot({LEVELS_W{1'b1}});
      repeat (4) send_snapshot(~(64'd1 << 63));
      repeat (5) send_snapshot({LEVELS_W{1'b1}});
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Limits of one and zero confirm on the first held sample after the pick.
      // The phase after the longest limit starts with a held key and a much lower limit.
      run_phase(1'b1, 5, 150, 1'b0);
      run_phase(1'b0, 2, 150, 1'b0);
      run_phase(1'b1, 3, 150, 1'b1);
      run_phase(1'b0, 1, 100, 1'b0);
      run_phase(1'b1, 0, 80, 1'b0);
      run_phase(1'b1, 255, 60, 1'b0);
      run_phase(1'b1, 3, 60, 1'b0);
      run_phase(1'b0, $urandom_range(4, 12), 150, 1'b0);

      drain_presses();

      if (tracker.pending() != 0)
         tracker.report_mismatch($sformatf("%0d presses never came out", tracker.pending()));
      $display("Covered %0d matrix snapshots over %0d register settings (both polarities,",
               snapshots_sent, settings_applied);
      $display("limits 0 to 255) and checked %0d confirmed key presses.",
               tracker.presses_checked);
      if (tracker.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
